// ===== hdl/ibfp_pkg.sv =====
package ibfp_pkg;

	localparam logic [7:0] HDR_BYTE   = 8'h55;
	localparam logic [7:0] TYPE_ANGLE = 8'h53;
	localparam logic [7:0] TYPE_FIELD = 8'h54;

	localparam logic KIND_ANGLE = 1'b0;
	localparam logic KIND_FIELD = 1'b1;

	typedef enum logic [10:0] {
		PH_HUNT  = 11'b000_0000_0001,
		PH_TYPE  = 11'b000_0000_0010,
		PH_XLO   = 11'b000_0000_0100,
		PH_XHI   = 11'b000_0000_1000,
		PH_YLO   = 11'b000_0001_0000,
		PH_YHI   = 11'b000_0010_0000,
		PH_ZLO   = 11'b000_0100_0000,
		PH_ZHI   = 11'b000_1000_0000,
		PH_SKIP0 = 11'b001_0000_0000,
		PH_SKIP1 = 11'b010_0000_0000,
		PH_SKIP2 = 11'b100_0000_0000
	} phase_t;

endpackage

// ===== hdl/imu_binary_frame_parser.sv =====
// Serial IMU frame parser: takes one received byte per beat on the input
// channel and hunts for an 11-byte frame opening with header 0x55 and type
// 0x53 (attitude angles) or 0x54 (magnetic field). The three little-endian
// signed 16-bit values of bytes 2 to 7 are sent out as one result beat with
// frame_kind 0 for angles (raw units of 180/32768 degree) and 1 for field.
// The last three bytes, checksum included, are skipped unchecked; a 0x55
// inside a frame is data, and a repeated 0x55 in the type slot keeps the
// header armed. A byte is accepted every clock cycle: each byte is captured
// in an input register, from which the phase logic updates the frame state
// and, on the last data byte, loads the result register. Only a stalled
// result register holding up a byte that completes the next frame stops the
// input.
module imu_binary_frame_parser
	import ibfp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               frame_kind,
	output logic signed [15:0] x_value,
	output logic signed [15:0] y_value,
	output logic signed [15:0] z_value
);

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        v_s2;
	logic        kind_s2;
	logic [15:0] x_s2;
	logic [15:0] y_s2;
	logic [15:0] z_s2;

	phase_t      phase_q;
	phase_t      phase_d;
	logic        kind_q;
	logic [7:0]  low_q;
	logic [15:0] first_q;
	logic [15:0] second_q;

	logic        out_free;
	logic        fire_s1;
	logic        emit;

	assign out_free = !v_s2 || out_ready;
	assign fire_s1  = v_s1 && ((phase_q != PH_ZHI) || out_free);
	assign emit     = fire_s1 && (phase_q == PH_ZHI);
	assign in_ready = !v_s1 || fire_s1;

	always_comb begin
		unique case (phase_q)
			PH_TYPE: begin
				if (byte_s1 == TYPE_ANGLE || byte_s1 == TYPE_FIELD) begin
					phase_d = PH_XLO;
				end else if (byte_s1 == HDR_BYTE) begin
					phase_d = PH_TYPE;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_XLO:   phase_d = PH_XHI;
			PH_XHI:   phase_d = PH_YLO;
			PH_YLO:   phase_d = PH_YHI;
			PH_YHI:   phase_d = PH_ZLO;
			PH_ZLO:   phase_d = PH_ZHI;
			PH_ZHI:   phase_d = PH_SKIP0;
			PH_SKIP0: phase_d = PH_SKIP1;
			PH_SKIP1: phase_d = PH_SKIP2;
			PH_SKIP2: phase_d = PH_HUNT;
			default:  phase_d = (byte_s1 == HDR_BYTE) ? PH_TYPE : PH_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			kind_q   <= KIND_ANGLE;
			low_q    <= '0;
			first_q  <= '0;
			second_q <= '0;
		end else if (fire_s1) begin
			phase_q <= phase_d;
			if (phase_q == PH_TYPE) begin
				if (byte_s1 == TYPE_ANGLE) begin
					kind_q <= KIND_ANGLE;
				end else if (byte_s1 == TYPE_FIELD) begin
					kind_q <= KIND_FIELD;
				end
			end
			if (phase_q == PH_XLO || phase_q == PH_YLO || phase_q == PH_ZLO) begin
				low_q <= byte_s1;
			end
			if (phase_q == PH_XHI) begin
				first_q <= {byte_s1, low_q};
			end
			if (phase_q == PH_YHI) begin
				second_q <= {byte_s1, low_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (emit) begin
			v_s2 <= 1'b1;
		end else if (out_ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_s2 <= kind_q;
			x_s2    <= first_q;
			y_s2    <= second_q;
			z_s2    <= {byte_s1, low_q};
		end
	end

	assign out_valid  = v_s2;
	assign frame_kind = kind_s2;
	assign x_value    = signed'(x_s2);
	assign y_value    = signed'(y_s2);
	assign z_value    = signed'(z_s2);

`ifndef NO_ASSERTIONS
	a_phase_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("frame phase lost its one-hot code");

	a_result_from_zhi: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(phase_q == PH_ZHI && fire_s1))
		else $error("result raised outside the last data byte");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid && phase_q == PH_SKIP0)
		else $error("completed frame did not load the result register");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && phase_q == PH_ZHI && v_s2 && !out_ready)
		else $error("input stalled without a blocked result");
`endif

endmodule
